[src/bms_pkg.sv]
package bms_pkg;

	// field widths
	localparam int CP_W = 21;
	localparam int CNT_W = 20;
	localparam int PAIR_W = 2 * CP_W;
	localparam int CFG_IDX_W = 3;
	localparam int PCNT_W = 3;

	// bracket pair registers and the cap on pairs in use
	localparam int NUM_PAIR_REGS = 4;
	localparam int MAX_PAIRS = 4;
	localparam int PAIRS_LIMIT = (MAX_PAIRS < NUM_PAIR_REGS) ? MAX_PAIRS : NUM_PAIR_REGS;

	// nesting counter default width
	localparam int DEPTH_BITS_DEF = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_CHAR  = 2'd1,
		CMD_END   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_SEARCH   = 3'd0,
		ST_NOT_AT   = 3'd1,
		ST_CORRECT  = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_NO_MATCH = 3'd4,
		ST_IDLE     = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIR_0     = 3'd0,
		REG_PAIR_1     = 3'd1,
		REG_PAIR_2     = 3'd2,
		REG_PAIR_3     = 3'd3,
		REG_PAIR_COUNT = 3'd4,
		REG_SCAN_LIMIT = 3'd5
	} reg_idx_t;

	typedef logic [NUM_PAIR_REGS-1:0][PAIR_W-1:0] pair_arr_t;

	typedef struct packed {
		cmd_t            command;
		logic [CP_W-1:0] code_point;
		logic            same_context;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic             scan_backward;
		logic [CNT_W-1:0] offset;
	} out_item_t;

	// classified beat handed from front to back
	typedef struct packed {
		cmd_t            command;
		logic [CP_W-1:0] code_point;
		logic            same_context;
		logic            open_hit;
		logic            close_hit;
		logic            start_found;
		logic            start_backward;
		logic [CP_W-1:0] start_target;
	} cls_item_t;

	// reset values: ( ), { }, [ ] and an empty fourth pair
	localparam logic [PAIR_W-1:0] PAIR_0_RST = {21'h000028, 21'h000029};
	localparam logic [PAIR_W-1:0] PAIR_1_RST = {21'h00007B, 21'h00007D};
	localparam logic [PAIR_W-1:0] PAIR_2_RST = {21'h00005B, 21'h00005D};
	localparam logic [PAIR_W-1:0] PAIR_3_RST = '0;
	localparam logic [PCNT_W-1:0] PAIR_COUNT_RST = 3'd3;
	localparam logic [CNT_W-1:0] SCAN_LIMIT_RST = 20'd10000;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

[src/bms_front.sv]
module bms_front import bms_pkg::*; (
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	input  pair_arr_t           pairs,
	input  logic [PCNT_W-1:0]   pair_count,
	input  logic                q_full,
	output logic                push,
	output cls_item_t           push_item
);

	logic [PCNT_W-1:0]        n_used;
	logic [NUM_PAIR_REGS-1:0] open_hit;
	logic [NUM_PAIR_REGS-1:0] close_hit;
	logic [CP_W-1:0]          tgt_from_open;
	logic [CP_W-1:0]          tgt_from_close;

	// pairs in use, capped
	assign n_used = (pair_count > PCNT_W'(PAIRS_LIMIT)) ? PCNT_W'(PAIRS_LIMIT) : pair_count;

	// compare the code point against every pair half in parallel
	always_comb begin
		for (int i = 0; i < NUM_PAIR_REGS; i++) begin
			open_hit[i]  = (PCNT_W'(i) < n_used) &&
				(pairs[i][PAIR_W-1:CP_W] == in_data.code_point);
			close_hit[i] = (PCNT_W'(i) < n_used) &&
				(pairs[i][CP_W-1:0] == in_data.code_point);
		end
	end

	// lowest pair that hits wins
	always_comb begin
		tgt_from_open  = '0;
		tgt_from_close = '0;
		for (int i = NUM_PAIR_REGS - 1; i >= 0; i--) begin
			if (open_hit[i]) begin
				tgt_from_open = pairs[i][CP_W-1:0];
			end
			if (close_hit[i]) begin
				tgt_from_close = pairs[i][PAIR_W-1:CP_W];
			end
		end
	end

	// classified beat
	always_comb begin
		push_item.command        = in_data.command;
		push_item.code_point     = in_data.code_point;
		push_item.same_context   = in_data.same_context;
		push_item.open_hit       = |open_hit;
		push_item.close_hit      = |close_hit;
		push_item.start_found    = (|open_hit) || (|close_hit);
		push_item.start_backward = !(|open_hit);
		push_item.start_target   = (|open_hit) ? tgt_from_open : tgt_from_close;
	end

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

endmodule

[src/bms_queue.sv]
module bms_queue import bms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output cls_item_t head_item
);

	cls_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue with pointer gap");

endmodule

[src/bms_back.sv]
module bms_back import bms_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  cls_item_t        head_item,
	output logic             pop,
	input  logic [CNT_W-1:0] scan_limit,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	logic                  active_q;
	logic [CP_W-1:0]       target_q;
	logic                  backward_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [CNT_W-1:0]      examined_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  active_d;
	logic [CP_W-1:0]       target_d;
	logic                  backward_d;
	logic [DEPTH_BITS-1:0] depth_d;
	logic [CNT_W-1:0]      examined_d;
	status_t               status_d;
	logic                  own_hit;
	logic                  other_hit;

	// take a beat whenever the output register is free or being drained
	assign pop = head_valid && (!out_valid_q || out_ready);

	assign own_hit   = backward_q ? head_item.close_hit : head_item.open_hit;
	assign other_hit = backward_q ? head_item.open_hit : head_item.close_hit;

	// next search state and status for the head beat
	always_comb begin
		active_d   = active_q;
		target_d   = target_q;
		backward_d = backward_q;
		depth_d    = depth_q;
		examined_d = examined_q;
		status_d   = active_q ? ST_SEARCH : ST_IDLE;
		unique case (head_item.command)
			CMD_START: begin
				depth_d    = '0;
				examined_d = '0;
				target_d   = head_item.start_target;
				if (!head_item.start_found) begin
					active_d   = 1'b0;
					backward_d = 1'b0;
					status_d   = ST_NOT_AT;
				end else if (scan_limit == '0) begin
					active_d   = 1'b0;
					backward_d = head_item.start_backward;
					status_d   = ST_NO_MATCH;
				end else begin
					active_d   = 1'b1;
					backward_d = head_item.start_backward;
					status_d   = ST_SEARCH;
				end
			end
			CMD_END: begin
				if (active_q) begin
					active_d = 1'b0;
					status_d = ST_NO_MATCH;
				end
			end
			CMD_CHAR: begin
				if (active_q) begin
					// count saturates at all ones
					examined_d = (examined_q != CNT_MAX) ? examined_q + 1'b1 : examined_q;
					status_d   = ST_SEARCH;
					if (head_item.same_context && (head_item.code_point == target_q) &&
						(depth_q == '0)) begin
						active_d = 1'b0;
						status_d = ST_CORRECT;
					end else if (head_item.same_context && own_hit) begin
						if (depth_q != '1) begin
							depth_d = depth_q + 1'b1;
						end
					end else if (head_item.same_context && other_hit) begin
						if (depth_q != '0) begin
							depth_d = depth_q - 1'b1;
						end else begin
							active_d = 1'b0;
							status_d = ST_MISMATCH;
						end
					end
					// limit check only when still searching
					if (status_d == ST_SEARCH && scan_limit != CNT_MAX &&
						examined_d >= scan_limit) begin
						active_d = 1'b0;
						status_d = ST_NO_MATCH;
					end
				end
			end
			CMD_NONE: begin
				status_d = active_q ? ST_SEARCH : ST_IDLE;
			end
			default: begin
				status_d = active_q ? ST_SEARCH : ST_IDLE;
			end
		endcase
	end

	// search state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			target_q    <= '0;
			backward_q  <= 1'b0;
			depth_q     <= '0;
			examined_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q    <= active_d;
				target_q    <= target_d;
				backward_q  <= backward_d;
				depth_q     <= depth_d;
				examined_q  <= examined_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.status        <= status_d;
			out_q.scan_backward <= backward_d;
			out_q.offset        <= examined_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q) else $error("popped beat not presented");
	a_not_at_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_NOT_AT) |->
		(out_q.offset == '0 && !out_q.scan_backward)) else $error("not_at_bracket with stale fields");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (status_d == ST_CORRECT || status_d == ST_MISMATCH || status_d == ST_NO_MATCH ||
		status_d == ST_NOT_AT)) |=> !active_q) else $error("search left active after final status");
	a_search_active: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && status_d == ST_SEARCH) |=> active_q) else $error("searching status while inactive");

endmodule

[src/bracket_match_scanner.sv]
// Channel   Handshake             Payload      Moves
// in        in_valid / in_ready   in_item_t    command, code point, context flag
// out       out_valid / out_ready out_item_t   status, direction, offset (one per input beat)
// cfg       cfg_we                cfg_index    register write, cfg_data, no wait
//
// One beat a cycle sustained while out_ready stays high: the front classifies against the pair
// registers in the accept cycle, the back does the compare and counter update for each beat.
// Between input accept and result valid lie the queue write and the output register load.
// A two-entry queue between front and back lets input and output stall independently.
// Reset (arst_n, asynchronous) clears the search state and loads the default bracket set.
module bracket_match_scanner import bms_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAIR_W-1:0]    cfg_data
);

	pair_arr_t         pair_q;
	logic [PCNT_W-1:0] pair_count_q;
	logic [CNT_W-1:0]  scan_limit_q;

	logic      push;
	cls_item_t push_item;
	logic      q_full;
	logic      pop;
	logic      head_valid;
	cls_item_t head_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q[0]    <= PAIR_0_RST;
			pair_q[1]    <= PAIR_1_RST;
			pair_q[2]    <= PAIR_2_RST;
			pair_q[3]    <= PAIR_3_RST;
			pair_count_q <= PAIR_COUNT_RST;
			scan_limit_q <= SCAN_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PAIR_0:     pair_q[0] <= cfg_data;
				REG_PAIR_1:     pair_q[1] <= cfg_data;
				REG_PAIR_2:     pair_q[2] <= cfg_data;
				REG_PAIR_3:     pair_q[3] <= cfg_data;
				REG_PAIR_COUNT: pair_count_q <= cfg_data[PCNT_W-1:0];
				REG_SCAN_LIMIT: scan_limit_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bms_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.pairs      (pair_q),
		.pair_count (pair_count_q),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	bms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bms_back #(
		.DEPTH_BITS (DEPTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.scan_limit (scan_limit_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

[bench/bms_checker.sv]
module bms_checker import bms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAIR_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the register file
	logic [PAIR_W-1:0] pair_cfg [NUM_PAIR_REGS];
	logic [PCNT_W-1:0] count_cfg;
	logic [CNT_W-1:0]  limit_cfg;

	// shadow search state
	logic                      searching;
	logic [CP_W-1:0]           target_cp;
	logic                      scan_bwd;
	logic [DEPTH_BITS_DEF-1:0] nest_depth;
	logic [CNT_W-1:0]          chars_seen;

	// predicted results still to come out, oldest first
	out_item_t scan_results_due [$];

	task automatic report_mismatch(string what);
		$display("bms_checker: %s at %0t", what, $time);
		fail_count++;
	endtask

	// too large a count falls back to the pairs available
	function automatic int pairs_used();
		return (count_cfg > PAIRS_LIMIT) ? PAIRS_LIMIT : int'(count_cfg);
	endfunction

	// is c a bracket of the given side (0 opening, 1 closing) among the pairs in use
	function automatic logic side_hit(logic closing, logic [CP_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < pairs_used(); i++)
			if ((closing ? pair_cfg[i][CP_W-1:0] : pair_cfg[i][PAIR_W-1:CP_W]) == c)
				hit = 1'b1;
		return hit;
	endfunction

	// advance the shadow search by one input beat and give the result it causes
	function automatic out_item_t next_scan_result(in_item_t it);
		out_item_t res;
		status_t   st;
		logic      found;
		logic      settled;
		int        n;
		n = pairs_used();
		st = ST_SEARCH;
		if (it.command == CMD_START) begin
			found = 1'b0;
			for (int i = 0; i < n; i++)
				if (!found && pair_cfg[i][PAIR_W-1:CP_W] == it.code_point) begin
					target_cp = pair_cfg[i][CP_W-1:0];
					scan_bwd = 1'b0;
					found = 1'b1;
				end
			for (int i = 0; i < n; i++)
				if (!found && pair_cfg[i][CP_W-1:0] == it.code_point) begin
					target_cp = pair_cfg[i][PAIR_W-1:CP_W];
					scan_bwd = 1'b1;
					found = 1'b1;
				end
			nest_depth = '0;
			chars_seen = '0;
			if (!found) begin
				searching = 1'b0;
				scan_bwd = 1'b0;
				st = ST_NOT_AT;
			end else if (limit_cfg == '0) begin
				searching = 1'b0;
				st = ST_NO_MATCH;
			end else begin
				searching = 1'b1;
			end
		end else if (it.command == CMD_NONE || !searching) begin
			st = searching ? ST_SEARCH : ST_IDLE;
		end else if (it.command == CMD_END) begin
			searching = 1'b0;
			st = ST_NO_MATCH;
		end else begin
			settled = 1'b0;
			if (chars_seen != CNT_MAX)
				chars_seen++;
			// only characters of the starting context take part in the nesting
			if (it.same_context) begin
				if (it.code_point == target_cp && nest_depth == '0) begin
					searching = 1'b0;
					st = ST_CORRECT;
					settled = 1'b1;
				end else if (side_hit(scan_bwd, it.code_point)) begin
					if (nest_depth != '1)
						nest_depth++;
				end else if (side_hit(!scan_bwd, it.code_point)) begin
					if (nest_depth != '0) begin
						nest_depth--;
					end else begin
						searching = 1'b0;
						st = ST_MISMATCH;
						settled = 1'b1;
					end
				end
			end
			if (!settled && limit_cfg != CNT_MAX && chars_seen >= limit_cfg) begin
				searching = 1'b0;
				st = ST_NO_MATCH;
			end
		end
		res.status = st;
		res.scan_backward = scan_bwd;
		res.offset = chars_seen;
		return res;
	endfunction

	// track writes, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pair_cfg[0] = PAIR_0_RST;
			pair_cfg[1] = PAIR_1_RST;
			pair_cfg[2] = PAIR_2_RST;
			pair_cfg[3] = PAIR_3_RST;
			count_cfg = PAIR_COUNT_RST;
			limit_cfg = SCAN_LIMIT_RST;
			searching = 1'b0;
			target_cp = '0;
			scan_bwd = 1'b0;
			nest_depth = '0;
			chars_seen = '0;
			scan_results_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index <= REG_PAIR_3)
					pair_cfg[cfg_index[1:0]] = cfg_data;
				else if (cfg_index == REG_PAIR_COUNT)
					count_cfg = cfg_data[PCNT_W-1:0];
				else if (cfg_index == REG_SCAN_LIMIT)
					limit_cfg = cfg_data[CNT_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (scan_results_due.size() == 0) begin
					report_mismatch("result beat with nothing predicted");
				end else begin
					want = scan_results_due.pop_front();
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							out_data.status, want.status));
					if (out_data.scan_backward !== want.scan_backward)
						report_mismatch($sformatf("scan_backward %0b, predicted %0b",
							out_data.scan_backward, want.scan_backward));
					if (out_data.offset !== want.offset)
						report_mismatch($sformatf("offset %0d, predicted %0d",
							out_data.offset, want.offset));
				end
			end
			if (in_valid && in_ready)
				scan_results_due.push_back(next_scan_result(in_data));
		end
		pending = scan_results_due.size();
	end

endmodule

[bench/tb_top.sv]
module tb_top;
	import bms_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DEEP_OPENS  = 12;

	localparam logic [CP_W-1:0] CP_LPAR  = 21'h28;
	localparam logic [CP_W-1:0] CP_RPAR  = 21'h29;
	localparam logic [CP_W-1:0] CP_LBRC  = 21'h7B;
	localparam logic [CP_W-1:0] CP_RBRC  = 21'h7D;
	localparam logic [CP_W-1:0] CP_LBRK  = 21'h5B;
	localparam logic [CP_W-1:0] CP_RBRK  = 21'h5D;
	localparam logic [CP_W-1:0] CP_LT    = 21'h3C;
	localparam logic [CP_W-1:0] CP_GT    = 21'h3E;
	localparam logic [CP_W-1:0] CP_QUOTE = 21'h22;
	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAIR_W-1:0]    cfg_data;

	int fail_count;
	int pending;
	int cycles = 0;

	// stimulus side view of the brackets in use
	logic [CP_W-1:0] open_cp [NUM_PAIR_REGS];
	logic [CP_W-1:0] close_cp [NUM_PAIR_REGS];
	int              pairs_on;
	logic            idle_on;
	logic            hold_req;

	always #(CLK_PERIOD / 2) clk = ~clk;

	bracket_match_scanner #(.DEPTH_BITS(DEPTH_BITS_DEF)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bms_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(0, 5)) @(posedge clk);
			end
		end
	end

	// offer one beat, maybe after a gap, and wait for it to be taken
	task automatic send_beat(cmd_t c, logic [CP_W-1:0] cp, logic same);
		in_item_t it;
		it.command = c;
		it.code_point = cp;
		it.same_context = same;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop offering and let every predicted result drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [PAIR_W-1:0] d);
		if (idx == REG_PAIR_COUNT) begin
			pairs_on = (d[PCNT_W-1:0] > PAIRS_LIMIT) ? PAIRS_LIMIT : int'(d[PCNT_W-1:0]);
		end else if (idx <= REG_PAIR_3) begin
			open_cp[int'(idx)] = d[PAIR_W-1:CP_W];
			close_cp[int'(idx)] = d[CP_W-1:0];
		end
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CP_W-1:0] rand_cp();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CP_MAX;
			2:       return CP_LT;
			default: return CP_W'($urandom_range(0, int'(CP_MAX)));
		endcase
	endfunction

	// a bracket of one side among the pairs in use; out-of-range codes are never sent
	function automatic logic [CP_W-1:0] pick_side(logic closing);
		int i;
		logic [CP_W-1:0] c;
		if (pairs_on == 0)
			return rand_cp();
		i = $urandom_range(0, pairs_on - 1);
		c = closing ? close_cp[i] : open_cp[i];
		return (c > CP_MAX) ? rand_cp() : c;
	endfunction

	function automatic logic opens_backward(logic [CP_W-1:0] c);
		for (int i = 0; i < pairs_on; i++)
			if (open_cp[i] == c)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [CP_W-1:0] pick_code();
		case ($urandom_range(0, 7))
			0: return CP_LPAR;
			1: return CP_RBRK;
			2: return CP_LBRC;
			3: return CP_GT;
			4: return CP_MAX;
			5: return '0;
			default: return CP_W'($urandom_range(0, int'(CP_MAX)));
		endcase
	endfunction

	task automatic random_pairs();
		logic [CP_W-1:0] o;
		for (int i = 0; i < NUM_PAIR_REGS; i++) begin
			o = pick_code();
			set_reg(reg_idx_t'(i), {o, ($urandom_range(0, 5) == 0) ? o : pick_code()});
		end
	endtask

	// mostly well-formed searches with random content, some loose beats
	task automatic random_phase(int n);
		int              sent;
		int              len;
		int              r;
		logic [CP_W-1:0] s;
		logic            bwd;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) < 8) begin
				s = ($urandom_range(0, 7) == 0) ? rand_cp() : pick_side(1'($urandom_range(0, 1)));
				bwd = opens_backward(s);
				send_beat(CMD_START, s, 1'($urandom_range(0, 1)));
				len = $urandom_range(0, 14);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 19);
					if (r == 0)
						send_beat(CMD_NONE, rand_cp(), 1'($urandom_range(0, 1)));
					else if (r < 9)
						send_beat(CMD_CHAR, pick_side(bwd), $urandom_range(0, 5) != 0);
					else if (r < 13)
						send_beat(CMD_CHAR, pick_side(!bwd), $urandom_range(0, 5) != 0);
					else
						send_beat(CMD_CHAR, rand_cp(), $urandom_range(0, 3) != 0);
				end
				if ($urandom_range(0, 2) == 0)
					send_beat(CMD_END, rand_cp(), 1'($urandom_range(0, 1)));
				sent += len + 2;
			end else begin
				send_beat(cmd_t'($urandom_range(0, 3)), rand_cp(), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		open_cp[0] = PAIR_0_RST[PAIR_W-1:CP_W];
		close_cp[0] = PAIR_0_RST[CP_W-1:0];
		open_cp[1] = PAIR_1_RST[PAIR_W-1:CP_W];
		close_cp[1] = PAIR_1_RST[CP_W-1:0];
		open_cp[2] = PAIR_2_RST[PAIR_W-1:CP_W];
		close_cp[2] = PAIR_2_RST[CP_W-1:0];
		open_cp[3] = PAIR_3_RST[PAIR_W-1:CP_W];
		close_cp[3] = PAIR_3_RST[CP_W-1:0];
		pairs_on = int'(PAIR_COUNT_RST);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default brackets
		send_beat(CMD_CHAR, CP_RPAR, 1'b1);    // nothing started yet
		send_beat(CMD_END, '0, 1'b0);
		send_beat(CMD_NONE, CP_MAX, 1'b1);
		send_beat(CMD_START, CP_LPAR, 1'b1);
		send_beat(CMD_CHAR, CP_MAX, 1'b1);
		send_beat(CMD_CHAR, CP_LPAR, 1'b0);    // other context: counted, not compared
		send_beat(CMD_CHAR, CP_LBRC, 1'b1);    // deepens
		send_beat(CMD_CHAR, CP_RBRK, 1'b1);    // pops
		send_beat(CMD_NONE, '0, 1'b0);
		send_beat(CMD_CHAR, CP_RPAR, 1'b1);    // match
		send_beat(CMD_START, CP_RBRK, 1'b0);
		send_beat(CMD_CHAR, CP_RBRC, 1'b0);
		send_beat(CMD_CHAR, CP_LBRC, 1'b1);    // wrong opener at top level
		send_beat(CMD_START, CP_LBRC, 1'b1);
		send_beat(CMD_START, 21'h78, 1'b1);    // restart on a non-bracket
		send_beat(CMD_CHAR, CP_LPAR, 1'b1);
		send_beat(CMD_START, CP_RBRC, 1'b1);
		send_beat(CMD_CHAR, CP_RBRK, 1'b1);
		send_beat(CMD_CHAR, '0, 1'b1);
		send_beat(CMD_END, CP_MAX, 1'b1);
		send_beat(CMD_CHAR, CP_LBRC, 1'b1);    // idle after end of text
		send_beat(CMD_START, '0, 1'b0);        // fourth pair not in use
		send_beat(CMD_START, CP_RPAR, 1'b1);
		send_beat(CMD_CHAR, CP_LPAR, 1'b0);
		send_beat(CMD_CHAR, CP_LPAR, 1'b1);

		// random with the default set, long result hold-off at the start
		hold_req = 1'b1;
		random_phase(150);

		settle();
		set_reg(REG_PAIR_3, {CP_LT, CP_GT});
		set_reg(REG_PAIR_COUNT, PAIR_W'(4));
		random_phase(80);

		settle();
		set_reg(REG_PAIR_COUNT, PAIR_W'(0));
		random_phase(30);

		settle();
		random_pairs();
		set_reg(REG_PAIR_COUNT, PAIR_W'(7));
		random_phase(80);

		// a pair whose two halves are the same character
		settle();
		set_reg(REG_PAIR_1, {CP_QUOTE, CP_QUOTE});
		random_phase(60);

		settle();
		set_reg(REG_SCAN_LIMIT, PAIR_W'(0));
		random_phase(30);

		settle();
		set_reg(REG_SCAN_LIMIT, PAIR_W'(1));
		random_phase(40);

		settle();
		set_reg(REG_SCAN_LIMIT, PAIR_W'(4));
		random_phase(60);

		settle();
		set_reg(REG_SCAN_LIMIT, PAIR_W'(CNT_MAX));
		random_pairs();
		set_reg(REG_PAIR_COUNT, PAIR_W'(2));
		random_phase(60);

		// register extremes
		settle();
		set_reg(REG_PAIR_2, '1);
		set_reg(REG_PAIR_3, '0);
		set_reg(REG_PAIR_COUNT, PAIR_W'(4));
		set_reg(REG_SCAN_LIMIT, PAIR_W'(CNT_MAX - 1));
		random_phase(40);

		// last part at full rate: defaults back, then a deep nest of one pair
		settle();
		idle_on = 1'b0;
		set_reg(REG_PAIR_0, PAIR_0_RST);
		set_reg(REG_PAIR_1, PAIR_1_RST);
		set_reg(REG_PAIR_2, PAIR_2_RST);
		set_reg(REG_PAIR_COUNT, PAIR_W'(PAIR_COUNT_RST));
		set_reg(REG_SCAN_LIMIT, PAIR_W'(SCAN_LIMIT_RST));
		random_phase(100);

		settle();
		set_reg(REG_PAIR_COUNT, PAIR_W'(1));
		set_reg(REG_SCAN_LIMIT, PAIR_W'(CNT_MAX));
		send_beat(CMD_START, CP_LPAR, 1'b1);
		for (int k = 0; k < DEEP_OPENS; k++)
			send_beat(CMD_CHAR, CP_LPAR, 1'b1);
		for (int k = 0; k < DEEP_OPENS; k++)
			send_beat(CMD_CHAR, CP_RPAR, 1'b1);
		send_beat(CMD_CHAR, CP_RPAR, 1'b1);    // back at depth 0: this one matches

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
